// ----- rtl/core/amc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_pkg: shared types and constants
// Command bundle, item codes and arithmetic helpers for the transform
// matrix accumulator.
// ---------------------------------------------------------------------------
package amc_pkg;

    localparam int MATRIX_DIM_C   = 4;
    localparam int FRAC_BITS_C    = 16;
    localparam int NUM_ELEMS      = MATRIX_DIM_C * MATRIX_DIM_C;
    localparam int ELEM_IDX_W     = $clog2(NUM_ELEMS);
    localparam int CORDIC_STEPS   = 24;
    localparam int MOD_STEPS      = 8;
    localparam int MAC_ISSUE      = NUM_ELEMS * MATRIX_DIM_C;
    localparam int MAC_LEN        = MAC_ISSUE + 2;
    localparam int CNT_W          = 7;
    localparam logic [15:0] TOL_RESET = 16'd66;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_LOAD      = 2'd0,
        KIND_TRANSLATE = 2'd1,
        KIND_ROTATE    = 2'd2,
        KIND_SCALE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } t_axis;

    typedef struct packed {
        logic             accept;
        logic             mod_step;
        logic             fold;
        logic             rot_step;
        logic             trig;
        logic             mul;
        logic             emit;
        logic [CNT_W-1:0] step;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // arctangent of 2^-i in degrees, 24 fraction bits
    function automatic logic [31:0] atan_deg(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd754974720;
            5'd1:    r = 32'd445687602;
            5'd2:    r = 32'd235489088;
            5'd3:    r = 32'd119537938;
            5'd4:    r = 32'd60000934;
            5'd5:    r = 32'd30029717;
            5'd6:    r = 32'd15018523;
            5'd7:    r = 32'd7509720;
            5'd8:    r = 32'd3754917;
            5'd9:    r = 32'd1877466;
            5'd10:   r = 32'd938734;
            5'd11:   r = 32'd469367;
            5'd12:   r = 32'd234684;
            5'd13:   r = 32'd117342;
            5'd14:   r = 32'd58671;
            5'd15:   r = 32'd29335;
            5'd16:   r = 32'd14668;
            5'd17:   r = 32'd7334;
            5'd18:   r = 32'd3667;
            5'd19:   r = 32'd1833;
            5'd20:   r = 32'd917;
            5'd21:   r = 32'd458;
            5'd22:   r = 32'd229;
            5'd23:   r = 32'd115;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/amc_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_ctrl: sequencer
// Walks angle reduction, CORDIC, multiply-accumulate and emission phases
// and issues one command word per cycle to the datapath.
// ---------------------------------------------------------------------------
module amc_ctrl
    import amc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_kind,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD    = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_CORDIC = 3'd3;
    localparam logic [2:0] S_TRIG   = 3'd4;
    localparam logic [2:0] S_MAC    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    case (i_kind)
                        KIND_ROTATE:                  n_state = S_MOD;
                        KIND_TRANSLATE, KIND_SCALE:   n_state = S_MAC;
                        default:                      n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD: begin
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                    n_state = S_FOLD;
                    n_cnt   = '0;
                end
            end
            S_FOLD: begin
                n_state = S_CORDIC;
                n_cnt   = '0;
            end
            S_CORDIC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_TRIG;
                    n_cnt   = '0;
                end
            end
            S_TRIG: begin
                n_state = S_MAC;
                n_cnt   = '0;
            end
            S_MAC: begin
                if (r_cnt == CNT_W'(MAC_LEN - 1)) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end
            end
            S_EMIT: begin
                if (r_cnt == CNT_W'(NUM_ELEMS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.mod_step = (r_state == S_MOD);
        o_cmd.fold     = (r_state == S_FOLD);
        o_cmd.rot_step = (r_state == S_CORDIC);
        o_cmd.trig     = (r_state == S_TRIG);
        o_cmd.mul      = (r_state == S_MAC) && (r_cnt < CNT_W'(MAC_ISSUE));
        o_cmd.emit     = (r_state == S_EMIT);
        o_cmd.step     = r_cnt;
    end

    a_mac_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_cnt == CNT_W'(MAC_LEN - 1)) |=> (r_state == S_EMIT))
        else $error("multiply phase did not hand over to emission");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_cnt == CNT_W'(NUM_ELEMS - 1)) |=> (r_state == S_IDLE))
        else $error("emission ran past the last element");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_LOAD) |=> (r_state == S_IDLE))
        else $error("element load left the idle state");

endmodule

// ----- rtl/core/amc_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_datapath: matrix store, CORDIC and multiply-accumulate
// Holds the matrix and the tolerance register, reduces the angle, runs the
// shared CORDIC and MAC units and drives the result registers.
// ---------------------------------------------------------------------------
module amc_datapath
    import amc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic signed [31:0] i_z_value,
    input  logic signed [31:0] i_angle_degrees,
    input  logic               i_cfg_write,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [3:0]         o_out_index,
    output logic signed [31:0] o_out_value,
    output logic               o_last
);

    localparam int                 FRAC_BITS = FRAC_BITS_C;
    localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF     = 64'sd1 <<< (FRAC_BITS - 1);
    localparam int                 RSH      = 30 - FRAC_BITS;
    localparam logic signed [63:0] HALF_Q   = 64'sd1 <<< (RSH - 1);
    localparam logic [40:0]        FULL     = 41'd360 << 24;
    localparam logic signed [34:0] FULL_S   = 35'sd360 <<< 24;
    localparam logic signed [34:0] HALFT    = 35'sd180 <<< 24;
    localparam logic signed [34:0] QUARTER  = 35'sd90 <<< 24;

    logic signed [31:0] r_mat [NUM_ELEMS];
    logic signed [31:0] r_res [NUM_ELEMS];
    logic [15:0]        r_tol;
    logic [1:0]         r_kind;
    logic [1:0]         r_axis;
    logic signed [31:0] r_x, r_y, r_z;
    logic [40:0]        r_zm;
    logic signed [34:0] r_za;
    logic signed [33:0] r_cx, r_cy;
    logic               r_flip;
    logic signed [31:0] r_sin, r_cos;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_v1;
    logic [5:0]         r_tag1;

    // axis detection on the incoming item
    function automatic logic near_one(input logic signed [31:0] c, input logic [15:0] tol);
        logic signed [33:0] d;
        logic [33:0]        m;
        d = {{2{c[31]}}, c} - 34'(ONE);
        m = d[33] ? 34'(-d) : 34'(d);
        return m < {18'd0, tol};
    endfunction

    logic [1:0] axis_in;
    always_comb begin
        if (near_one(i_x_value, r_tol)) begin
            axis_in = AXIS_X;
        end else if (near_one(i_y_value, r_tol)) begin
            axis_in = AXIS_Y;
        end else if (near_one(i_z_value, r_tol)) begin
            axis_in = AXIS_Z;
        end else begin
            axis_in = AXIS_NONE;
        end
    end

    // angle to 24 fraction bits, shifted into the nonnegative range
    logic signed [41:0] z_in;
    assign z_in = {{2{i_angle_degrees[31]}}, i_angle_degrees, {(24 - FRAC_BITS){1'b0}}}
                + (i_angle_degrees[31] ? $signed({1'b0, FULL << 7}) : 42'sd0);

    // restoring reduction modulo a full turn, one bit per step
    logic [40:0] mod_sub;
    assign mod_sub = FULL << (3'd7 - i_cmd.step[2:0]);

    // fold into [-90, 90]
    logic signed [34:0] z_half, z_fold;
    logic               flip_fold;
    always_comb begin
        z_half    = (r_zm >= 41'(HALFT)) ? $signed(35'(r_zm)) - FULL_S : $signed(35'(r_zm));
        z_fold    = z_half;
        flip_fold = 1'b0;
        if (z_half > QUARTER) begin
            z_fold    = z_half - HALFT;
            flip_fold = 1'b1;
        end else if (z_half < -QUARTER) begin
            z_fold    = z_half + HALFT;
            flip_fold = 1'b1;
        end
    end

    // CORDIC step
    logic [4:0]         rot_i;
    logic signed [33:0] dx, dy;
    logic signed [34:0] atan_v;
    assign rot_i  = i_cmd.step[4:0];
    assign dx     = r_cy >>> rot_i;
    assign dy     = r_cx >>> rot_i;
    assign atan_v = $signed({3'b000, atan_deg(rot_i)});

    // round Q4.30 to the output fraction width
    logic signed [63:0] cx_f, cy_f;
    assign cx_f = r_flip ? -64'(r_cx) : 64'(r_cx);
    assign cy_f = r_flip ? -64'(r_cy) : 64'(r_cy);

    // elementary matrix element for the current product
    logic [5:0] mstep;
    logic [1:0] mi, mj, mr;
    logic [3:0] a_idx, b_idx;
    assign mstep = i_cmd.step[5:0];
    assign mr    = mstep[1:0];
    assign mi    = mstep[3:2];
    assign mj    = mstep[5:4];
    assign a_idx = {mr, mi};
    assign b_idx = {mj, mr};

    logic signed [31:0] b_val;
    always_comb begin
        b_val = (b_idx == 4'd0 || b_idx == 4'd5 || b_idx == 4'd10 || b_idx == 4'd15)
              ? ONE : 32'sd0;
        case (r_kind)
            KIND_TRANSLATE: begin
                if (b_idx == 4'd12) b_val = r_x;
                if (b_idx == 4'd13) b_val = r_y;
                if (b_idx == 4'd14) b_val = r_z;
            end
            KIND_SCALE: begin
                if (b_idx == 4'd0)  b_val = r_x;
                if (b_idx == 4'd5)  b_val = r_y;
                if (b_idx == 4'd10) b_val = r_z;
            end
            KIND_ROTATE: begin
                case (r_axis)
                    AXIS_X: begin
                        if (b_idx == 4'd5 || b_idx == 4'd10) b_val = r_cos;
                        if (b_idx == 4'd6)  b_val = r_sin;
                        if (b_idx == 4'd9)  b_val = -r_sin;
                    end
                    AXIS_Y: begin
                        if (b_idx == 4'd0 || b_idx == 4'd10) b_val = r_cos;
                        if (b_idx == 4'd8)  b_val = r_sin;
                        if (b_idx == 4'd2)  b_val = -r_sin;
                    end
                    AXIS_Z: begin
                        if (b_idx == 4'd0 || b_idx == 4'd5) b_val = r_cos;
                        if (b_idx == 4'd1)  b_val = r_sin;
                        if (b_idx == 4'd4)  b_val = -r_sin;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    logic signed [63:0] term, acc_next;
    assign term     = (r_prod + HALF) >>> FRAC_BITS;
    assign acc_next = (r_tag1[1:0] == 2'd0) ? term : r_acc + term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_write) begin
            r_tol <= i_cfg_data;
        end
    end

    // matrix store: one write per cycle, load or emission sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ELEMS; k++) begin
                r_mat[k] <= ((k % MATRIX_DIM_C) == (k / MATRIX_DIM_C)) ? ONE : 32'sd0;
            end
        end else if (i_cmd.accept && i_kind == KIND_LOAD) begin
            r_mat[i_elem_index] <= i_elem_value;
        end else if (i_cmd.emit) begin
            r_mat[i_cmd.step[3:0]] <= r_res[i_cmd.step[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_axis <= axis_in;
            r_x    <= i_x_value;
            r_y    <= i_y_value;
            r_z    <= i_z_value;
            r_zm   <= z_in[40:0];
        end
        if (i_cmd.mod_step && r_zm >= mod_sub) begin
            r_zm <= r_zm - mod_sub;
        end
        if (i_cmd.fold) begin
            r_za   <= z_fold;
            r_flip <= flip_fold;
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
        end
        if (i_cmd.rot_step) begin
            if (!r_za[34]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_za <= r_za - atan_v;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_za <= r_za + atan_v;
            end
        end
        if (i_cmd.trig) begin
            r_cos <= sat32((cx_f + HALF_Q) >>> RSH);
            r_sin <= sat32((cy_f + HALF_Q) >>> RSH);
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_mat[a_idx]) * 64'(b_val);
            r_tag1 <= mstep;
        end
        if (r_v1) begin
            r_acc <= acc_next;
            if (r_tag1[1:0] == 2'd3) begin
                r_res[{r_tag1[5:4], r_tag1[3:2]}] <= sat32(acc_next);
            end
        end
        if (i_cmd.emit) begin
            o_out_index <= i_cmd.step[3:0];
            o_out_value <= r_res[i_cmd.step[3:0]];
            o_last      <= (i_cmd.step[3:0] == 4'(NUM_ELEMS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_cmd.mul;
            o_valid <= i_cmd.emit;
        end
    end

endmodule

// ----- rtl/core/affine_matrix_accumulator_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_matrix_accumulator_core: 4x4 transform matrix concatenation
// Keeps a column-major fixed-point matrix, right-multiplies it by translate,
// scale and rotate matrices and streams out the sixteen updated elements.
// ---------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy is low. A load writes one
// element and returns nothing. Translate and scale run the shared
// multiply-accumulate (one product per cycle over 64 products plus a two-stage
// drain) and then stream the 16 elements, one per cycle on o_valid, o_last on
// the sixteenth. Before that, rotate reduces the angle modulo a full turn,
// folds it, runs 24 CORDIC steps and rounds the sine and cosine. Results
// cannot be held off: each element is on the ports for exactly one cycle. The
// tolerance register takes a write whenever i_cfg_valid is high (o_cfg_ready
// is always high); write it only while o_busy is low.
module affine_matrix_accumulator_core
    import amc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic signed [31:0] i_z_value,
    input  logic signed [31:0] i_angle_degrees,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [3:0]         o_out_index,
    output logic signed [31:0] o_out_value,
    output logic               o_last
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    amc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    amc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_kind),
        .i_elem_index    (i_elem_index),
        .i_elem_value    (i_elem_value),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .i_z_value       (i_z_value),
        .i_angle_degrees (i_angle_degrees),
        .i_cfg_write     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_out_index     (o_out_index),
        .o_out_value     (o_out_value),
        .o_last          (o_last)
    );

endmodule
